FILE: sv/lpg_pkg.sv
// Package for the Lorentzian peak and gradient core: payload structs, codes,
// register defaults and the fixed datapath widths. No dependencies.
package lpg_pkg;

    // Configuration and payload widths
    localparam int CFG_W     = 32;
    localparam int WIDTH_W   = 31;
    localparam int IDX_W     = 3;
    localparam int CH_W      = 12;
    localparam int RES_W     = 48;

    // Datapath widths
    localparam int PROD_W    = CFG_W + CH_W + 1;      // step * channel, signed
    localparam int X_W       = PROD_W + 1;            // energy offset, signed
    localparam int AX_W      = 44;                    // |x| < 4097 * 2^31
    localparam int H_W       = CFG_W;                 // |height|
    localparam int X2_W      = 2 * AX_W;
    localparam int W2_W      = 2 * WIDTH_W;
    localparam int HW_W      = H_W + WIDTH_W;
    localparam int D_W       = X2_W + 3;              // 4*x^2 + w^2
    localparam int DD_W      = 2 * D_W;
    localparam int G1_W      = AX_W;
    localparam int G2_W      = D_W;
    localparam int G3_AW     = HW_W + X2_W;
    localparam int G3_BW     = AX_W;
    localparam int SH_DERIV  = 19;
    localparam int SH_HEIGHT = 16;
    localparam int NUM_W     = G3_AW + SH_DERIV;
    localparam int Q_W       = RES_W;
    localparam int MUL_CHUNK = 32;

    localparam logic [Q_W-1:0] Q_POS_LIM = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_NEG_LIM = {1'b1, {(Q_W-1){1'b0}}};

    // Register reset values
    localparam logic [CFG_W-1:0]   RST_ENERGY_START = 32'h0000_0000;
    localparam logic [CFG_W-1:0]   RST_ENERGY_STEP  = 32'h0001_0000;
    localparam logic [CFG_W-1:0]   RST_PEAK_CENTRE  = 32'h0000_0000;
    localparam logic [WIDTH_W-1:0] RST_PEAK_WIDTH   = 31'h000A_0000;
    localparam logic [CFG_W-1:0]   RST_PEAK_HEIGHT  = 32'h0001_0000;

    typedef enum logic [1:0] {
        OP_VALUE   = 2'd0,
        OP_DCENTRE = 2'd1,
        OP_DWIDTH  = 2'd2,
        OP_DHEIGHT = 2'd3
    } t_op;

    typedef enum logic [IDX_W-1:0] {
        REG_ENERGY_START = 3'd0,
        REG_ENERGY_STEP  = 3'd1,
        REG_PEAK_CENTRE  = 3'd2,
        REG_PEAK_WIDTH   = 3'd3,
        REG_PEAK_HEIGHT  = 3'd4
    } t_reg;

    typedef struct packed {
        t_op             op;
        logic [CH_W-1:0] channel;
    } t_in;

    typedef struct packed {
        logic signed [RES_W-1:0] result;
        logic                    saturated;
        logic                    divide_error;
    } t_out;

    typedef struct packed {
        t_op             op;
        logic            xneg;
        logic            hneg;
        logic [AX_W-1:0] ax;
        logic [H_W-1:0]  ah;
    } t_g1_sb;

    typedef struct packed {
        t_op             op;
        logic            neg;
        logic            dz;
        logic [D_W-1:0]  d;
        logic [AX_W-1:0] ax;
    } t_g2_sb;

    typedef struct packed {
        t_op             op;
        logic            neg;
        logic            dz;
        logic [D_W-1:0]  d;
        logic [DD_W-1:0] dd;
    } t_g3_sb;

    typedef struct packed {
        logic neg;
        logic dz;
    } t_div_sb;

endpackage

FILE: sv/lpg_mul.sv
// Pipelined wide unsigned multiplier: one chunk-by-chunk partial product per
// stage, several lanes side by side, sideband carried along. Needs no package.
module lpg_mul #(
    parameter int LANES = 1,
    parameter int AW    = 32,
    parameter int BW    = 32,
    parameter int SW    = 1,
    parameter int CW    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_v,
    input  logic [LANES-1:0][AW-1:0]        i_a,
    input  logic [LANES-1:0][BW-1:0]        i_b,
    input  logic [SW-1:0]                   i_sb,
    output logic                            o_v,
    output logic [LANES-1:0][AW+BW-1:0]     o_p,
    output logic [SW-1:0]                   o_sb
);
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int NS = NA * NB;
    localparam int AP = NA * CW;
    localparam int BP = NB * CW;
    localparam int PW = AW + BW;
    localparam int WW = AP + BP;

    logic                          r_v  [NS];
    logic [LANES-1:0][AP-1:0]      r_a  [NS];
    logic [LANES-1:0][BP-1:0]      r_b  [NS];
    logic [LANES-1:0][PW-1:0]      r_p  [NS];
    logic [SW-1:0]                 r_sb [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int IA = s / NB;
        localparam int IB = s % NB;
        localparam int SH = CW * (IA + IB);

        logic                     p_v;
        logic [LANES-1:0][AP-1:0] p_a;
        logic [LANES-1:0][BP-1:0] p_b;
        logic [LANES-1:0][PW-1:0] p_p;
        logic [SW-1:0]            p_sb;
        logic [LANES-1:0][PW-1:0] n_p;

        // Select the previous stage, or the inputs at the first stage
        if (s == 0) begin : g_first
            always_comb begin
                p_v  = i_v;
                p_sb = i_sb;
                p_p  = '0;
                for (int l = 0; l < LANES; l++) begin
                    p_a[l] = AP'(i_a[l]);
                    p_b[l] = BP'(i_b[l]);
                end
            end
        end else begin : g_next
            assign p_v  = r_v[s-1];
            assign p_a  = r_a[s-1];
            assign p_b  = r_b[s-1];
            assign p_p  = r_p[s-1];
            assign p_sb = r_sb[s-1];
        end

        // Add one partial product per lane
        always_comb begin
            logic [2*CW-1:0] part;
            logic [WW-1:0]   wide;
            for (int l = 0; l < LANES; l++) begin
                part   = p_a[l][IA*CW +: CW] * p_b[l][IB*CW +: CW];
                wide   = WW'(part) << SH;
                n_p[l] = p_p[l] + wide[PW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[s]  <= p_a;
                r_b[s]  <= p_b;
                r_p[s]  <= n_p;
                r_sb[s] <= p_sb;
            end
        end
    end

    assign o_v  = r_v[NS-1];
    assign o_p  = r_p[NS-1];
    assign o_sb = r_sb[NS-1];

endmodule

FILE: sv/lpg_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per
// stage. Needs no package.
module lpg_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_v,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_sb,
    output logic          o_v,
    output logic [QW-1:0] o_q,
    output logic          o_over,
    output logic [SW-1:0] o_sb
);
    localparam int XW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_v    [QW+1];
    logic [DW-1:0] r_rem  [QW+1];
    logic [QW-1:0] r_low  [QW+1];
    logic [QW-1:0] r_q    [QW+1];
    logic [DW-1:0] r_den  [QW+1];
    logic          r_over [QW+1];
    logic [SW-1:0] r_sb   [QW+1];

    // Check quotient range and split the numerator
    logic [XW-1:0] numx;
    logic [XW-1:0] limx;
    assign numx = XW'(i_num);
    assign limx = XW'({i_den, {QW{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= numx[QW +: DW];
            r_low[0]  <= numx[QW-1:0];
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_over[0] <= (numx >= limx);
            r_sb[0]   <= i_sb;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_q;

        // Shift in the next numerator bit, subtract where it fits
        always_comb begin
            t     = {r_rem[k-1], r_low[k-1][QW-1]};
            diff  = t - {1'b0, r_den[k-1]};
            ge    = (t >= {1'b0, r_den[k-1]});
            n_rem = ge ? diff[DW-1:0] : t[DW-1:0];
            n_q   = {r_q[k-1][QW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= r_low[k-1] << 1;
                r_q[k]    <= n_q;
                r_den[k]  <= r_den[k-1];
                r_over[k] <= r_over[k-1];
                r_sb[k]   <= r_sb[k-1];
            end
        end
    end

    assign o_v    = r_v[QW];
    assign o_q    = r_q[QW];
    assign o_over = r_over[QW];
    assign o_sb   = r_sb[QW];

endmodule

FILE: sv/lorentzian_peak_and_gradient_core.sv
// Lorentzian peak value and partial derivatives, one spectrum channel a request.
// Pipeline at the default 32-bit multiplier chunk (2 energy stages,
// 4 + 9 + 10 multiplier stages, 1 denominator stage, 49 divider stages,
// 1 output register). Throughput: one request per cycle unless the output
// is stalled; the 49-stage divider pipeline sets most of the depth.
// Reset clears all valid bits and loads the register defaults.
module lorentzian_peak_and_gradient_core #(
    parameter int CHUNK_W = lpg_pkg::MUL_CHUNK
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  lpg_pkg::t_in                 i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output lpg_pkg::t_out                o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lpg_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [lpg_pkg::CFG_W-1:0]    i_cfg_data
);
    // Configuration registers
    logic [lpg_pkg::CFG_W-1:0]   r_energy_start;
    logic [lpg_pkg::CFG_W-1:0]   r_energy_step;
    logic [lpg_pkg::CFG_W-1:0]   r_peak_centre;
    logic [lpg_pkg::WIDTH_W-1:0] r_peak_width;
    logic [lpg_pkg::CFG_W-1:0]   r_peak_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_start <= lpg_pkg::RST_ENERGY_START;
            r_energy_step  <= lpg_pkg::RST_ENERGY_STEP;
            r_peak_centre  <= lpg_pkg::RST_PEAK_CENTRE;
            r_peak_width   <= lpg_pkg::RST_PEAK_WIDTH;
            r_peak_height  <= lpg_pkg::RST_PEAK_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (lpg_pkg::t_reg'(i_cfg_index))
                lpg_pkg::REG_ENERGY_START: r_energy_start <= i_cfg_data;
                lpg_pkg::REG_ENERGY_STEP:  r_energy_step  <= i_cfg_data;
                lpg_pkg::REG_PEAK_CENTRE:  r_peak_centre  <= i_cfg_data;
                lpg_pkg::REG_PEAK_WIDTH:   r_peak_width   <= i_cfg_data[lpg_pkg::WIDTH_W-1:0];
                lpg_pkg::REG_PEAK_HEIGHT:  r_peak_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output register is held
    logic en;
    logic r_out_v;
    assign en         = !r_out_v || !i_out_stall;
    assign o_in_stall = !en;

    // Stage 1: step times channel
    logic signed [lpg_pkg::PROD_W-1:0] n_prod;
    logic                              r1_v;
    lpg_pkg::t_op                      r1_op;
    logic signed [lpg_pkg::PROD_W-1:0] r1_prod;

    assign n_prod = lpg_pkg::PROD_W'($signed(r_energy_step))
                  * lpg_pkg::PROD_W'($signed({1'b0, i_in_data.channel}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op   <= i_in_data.op;
            r1_prod <= n_prod;
        end
    end

    // Stage 2: energy offset and magnitudes
    logic signed [lpg_pkg::X_W-1:0] n_x;
    logic [lpg_pkg::X_W-1:0]        n_xabs;
    logic                           n_hneg;
    logic [lpg_pkg::H_W-1:0]        n_ah;
    logic                           r2_v;
    lpg_pkg::t_op                   r2_op;
    logic                           r2_xneg;
    logic                           r2_hneg;
    logic [lpg_pkg::AX_W-1:0]       r2_ax;
    logic [lpg_pkg::H_W-1:0]        r2_ah;
    logic [lpg_pkg::WIDTH_W-1:0]    r2_w;

    always_comb begin
        n_x    = lpg_pkg::X_W'($signed(r_energy_start)) + lpg_pkg::X_W'(r1_prod)
               - lpg_pkg::X_W'($signed(r_peak_centre));
        n_xabs = n_x[lpg_pkg::X_W-1] ? -n_x : n_x;
        n_hneg = r_peak_height[lpg_pkg::CFG_W-1];
        n_ah   = n_hneg ? -r_peak_height : r_peak_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op   <= r1_op;
            r2_xneg <= n_x[lpg_pkg::X_W-1];
            r2_hneg <= n_hneg;
            r2_ax   <= n_xabs[lpg_pkg::AX_W-1:0];
            r2_ah   <= n_ah;
            r2_w    <= r_peak_width;
        end
    end

    // Multiplier group 1: x^2, w^2, |h|*w
    logic [2:0][lpg_pkg::G1_W-1:0]   g1_a;
    logic [2:0][lpg_pkg::G1_W-1:0]   g1_b;
    logic [2:0][2*lpg_pkg::G1_W-1:0] g1_p;
    lpg_pkg::t_g1_sb                 g1_sb_in;
    lpg_pkg::t_g1_sb                 g1_sb;
    logic                            g1_v;

    always_comb begin
        g1_a[0]       = r2_ax;
        g1_b[0]       = r2_ax;
        g1_a[1]       = lpg_pkg::G1_W'(r2_w);
        g1_b[1]       = lpg_pkg::G1_W'(r2_w);
        g1_a[2]       = lpg_pkg::G1_W'(r2_ah);
        g1_b[2]       = lpg_pkg::G1_W'(r2_w);
        g1_sb_in.op   = r2_op;
        g1_sb_in.xneg = r2_xneg;
        g1_sb_in.hneg = r2_hneg;
        g1_sb_in.ax   = r2_ax;
        g1_sb_in.ah   = r2_ah;
    end

    lpg_mul #(
        .LANES (3),
        .AW    (lpg_pkg::G1_W),
        .BW    (lpg_pkg::G1_W),
        .SW    ($bits(lpg_pkg::t_g1_sb)),
        .CW    (CHUNK_W)
    ) u_mul_g1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r2_v),
        .i_a     (g1_a),
        .i_b     (g1_b),
        .i_sb    (g1_sb_in),
        .o_v     (g1_v),
        .o_p     (g1_p),
        .o_sb    (g1_sb)
    );

    // Stage D: denominator, sign and operands for the numerator product
    logic [lpg_pkg::X2_W-1:0] x2;
    logic [lpg_pkg::W2_W-1:0] w2;
    logic [lpg_pkg::HW_W-1:0] hw;
    logic [lpg_pkg::D_W-1:0]  n_d;
    logic                     n_neg;
    logic [lpg_pkg::G2_W-1:0] n_a1;
    logic [lpg_pkg::G2_W-1:0] n_b1;
    logic                     r3_v;
    lpg_pkg::t_op             r3_op;
    logic                     r3_neg;
    logic                     r3_dz;
    logic [lpg_pkg::D_W-1:0]  r3_d;
    logic [lpg_pkg::G2_W-1:0] r3_a1;
    logic [lpg_pkg::G2_W-1:0] r3_b1;
    logic [lpg_pkg::AX_W-1:0] r3_ax;

    always_comb begin
        x2  = g1_p[0][lpg_pkg::X2_W-1:0];
        w2  = g1_p[1][lpg_pkg::W2_W-1:0];
        hw  = g1_p[2][lpg_pkg::HW_W-1:0];
        n_d = lpg_pkg::D_W'({x2, 2'b00}) + lpg_pkg::D_W'(w2);
        case (g1_sb.op)
            lpg_pkg::OP_DCENTRE: n_neg = g1_sb.xneg ^ g1_sb.hneg;
            lpg_pkg::OP_DHEIGHT: n_neg = 1'b0;
            default:             n_neg = g1_sb.hneg;
        endcase
        case (g1_sb.op)
            lpg_pkg::OP_DWIDTH: begin
                n_a1 = lpg_pkg::G2_W'(hw);
                n_b1 = lpg_pkg::G2_W'(x2);
            end
            lpg_pkg::OP_DHEIGHT: begin
                n_a1 = lpg_pkg::G2_W'(w2);
                n_b1 = lpg_pkg::G2_W'(1'b1);
            end
            default: begin
                n_a1 = lpg_pkg::G2_W'(g1_sb.ah);
                n_b1 = lpg_pkg::G2_W'(w2);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= g1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_op  <= g1_sb.op;
            r3_neg <= n_neg;
            r3_dz  <= (n_d == '0);
            r3_d   <= n_d;
            r3_a1  <= n_a1;
            r3_b1  <= n_b1;
            r3_ax  <= g1_sb.ax;
        end
    end

    // Multiplier group 2: d^2 and the first numerator product
    logic [1:0][lpg_pkg::G2_W-1:0]   g2_a;
    logic [1:0][lpg_pkg::G2_W-1:0]   g2_b;
    logic [1:0][2*lpg_pkg::G2_W-1:0] g2_p;
    lpg_pkg::t_g2_sb                 g2_sb_in;
    lpg_pkg::t_g2_sb                 g2_sb;
    logic                            g2_v;

    always_comb begin
        g2_a[0]     = r3_d;
        g2_b[0]     = r3_d;
        g2_a[1]     = r3_a1;
        g2_b[1]     = r3_b1;
        g2_sb_in.op  = r3_op;
        g2_sb_in.neg = r3_neg;
        g2_sb_in.dz  = r3_dz;
        g2_sb_in.d   = r3_d;
        g2_sb_in.ax  = r3_ax;
    end

    lpg_mul #(
        .LANES (2),
        .AW    (lpg_pkg::G2_W),
        .BW    (lpg_pkg::G2_W),
        .SW    ($bits(lpg_pkg::t_g2_sb)),
        .CW    (CHUNK_W)
    ) u_mul_g2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r3_v),
        .i_a     (g2_a),
        .i_b     (g2_b),
        .i_sb    (g2_sb_in),
        .o_v     (g2_v),
        .o_p     (g2_p),
        .o_sb    (g2_sb)
    );

    // Multiplier group 3: times |x| for the centre derivative, else times one
    logic [0:0][lpg_pkg::G3_AW-1:0]              g3_a;
    logic [0:0][lpg_pkg::G3_BW-1:0]              g3_b;
    logic [0:0][lpg_pkg::G3_AW+lpg_pkg::G3_BW-1:0] g3_p;
    lpg_pkg::t_g3_sb                             g3_sb_in;
    lpg_pkg::t_g3_sb                             g3_sb;
    logic                                        g3_v;

    always_comb begin
        g3_a[0]      = g2_p[1][lpg_pkg::G3_AW-1:0];
        g3_b[0]      = (g2_sb.op == lpg_pkg::OP_DCENTRE) ? g2_sb.ax
                                                         : lpg_pkg::G3_BW'(1'b1);
        g3_sb_in.op  = g2_sb.op;
        g3_sb_in.neg = g2_sb.neg;
        g3_sb_in.dz  = g2_sb.dz;
        g3_sb_in.d   = g2_sb.d;
        g3_sb_in.dd  = g2_p[0];
    end

    lpg_mul #(
        .LANES (1),
        .AW    (lpg_pkg::G3_AW),
        .BW    (lpg_pkg::G3_BW),
        .SW    ($bits(lpg_pkg::t_g3_sb)),
        .CW    (CHUNK_W)
    ) u_mul_g3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (g2_v),
        .i_a     (g3_a),
        .i_b     (g3_b),
        .i_sb    (g3_sb_in),
        .o_v     (g3_v),
        .o_p     (g3_p),
        .o_sb    (g3_sb)
    );

    // Scale the numerator and pick the denominator per op
    logic [lpg_pkg::G3_AW-1:0] pl;
    logic [lpg_pkg::NUM_W-1:0] dv_num;
    logic [lpg_pkg::DD_W-1:0]  dv_den;
    lpg_pkg::t_div_sb          dv_sb_in;
    lpg_pkg::t_div_sb          dv_sb;
    logic                      dv_v;
    logic [lpg_pkg::Q_W-1:0]   dv_q;
    logic                      dv_over;

    always_comb begin
        pl = g3_p[0][lpg_pkg::G3_AW-1:0];
        case (g3_sb.op) inside
            lpg_pkg::OP_DCENTRE, lpg_pkg::OP_DWIDTH: begin
                dv_num = {pl, {lpg_pkg::SH_DERIV{1'b0}}};
                dv_den = g3_sb.dd;
            end
            lpg_pkg::OP_DHEIGHT: begin
                dv_num = lpg_pkg::NUM_W'({pl, {lpg_pkg::SH_HEIGHT{1'b0}}});
                dv_den = lpg_pkg::DD_W'(g3_sb.d);
            end
            default: begin
                dv_num = lpg_pkg::NUM_W'(pl);
                dv_den = lpg_pkg::DD_W'(g3_sb.d);
            end
        endcase
        dv_sb_in.neg = g3_sb.neg;
        dv_sb_in.dz  = g3_sb.dz;
    end

    lpg_div #(
        .NW (lpg_pkg::NUM_W),
        .DW (lpg_pkg::DD_W),
        .QW (lpg_pkg::Q_W),
        .SW ($bits(lpg_pkg::t_div_sb))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (g3_v),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .i_sb    (dv_sb_in),
        .o_v     (dv_v),
        .o_q     (dv_q),
        .o_over  (dv_over),
        .o_sb    (dv_sb)
    );

    // Saturate, apply sign, flag a zero denominator
    logic [lpg_pkg::Q_W-1:0] lim;
    logic                    sat;
    logic [lpg_pkg::Q_W-1:0] qs;
    lpg_pkg::t_out           n_out;
    lpg_pkg::t_out           r_out;

    always_comb begin
        lim = dv_sb.neg ? lpg_pkg::Q_NEG_LIM : lpg_pkg::Q_POS_LIM;
        sat = dv_over || (dv_q > lim);
        qs  = sat ? lim : dv_q;
        if (dv_sb.dz) begin
            n_out.result       = '0;
            n_out.saturated    = 1'b0;
            n_out.divide_error = 1'b1;
        end else begin
            n_out.result       = dv_sb.neg ? -qs : qs;
            n_out.saturated    = sat;
            n_out.divide_error = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Checks
    logic [lpg_pkg::RES_W-1:0] res_bits;
    assign res_bits = o_out_data.result;

    a_div_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.divide_error
            |-> res_bits == '0 && !o_out_data.saturated)
        else $error("divide error request carries a nonzero result");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated
            |-> res_bits == lpg_pkg::Q_POS_LIM || res_bits == lpg_pkg::Q_NEG_LIM)
        else $error("saturated result is not at a range limit");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("pipeline advanced while the output request was held");

endmodule
